/* rtl/pcd_pkg.sv */
package pcd_pkg;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_LEVEL_MAX    = 2'd0;
    localparam logic [1:0] REG_LEVEL_MIN    = 2'd1;
    localparam logic [1:0] REG_RAMP_DIVIDER = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0] RST_LEVEL_MAX    = 8'd200;
    localparam logic [7:0] RST_LEVEL_MIN    = 8'd20;
    localparam logic [7:0] RST_RAMP_DIVIDER = 8'd7;

    // Mode codes of an input word
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_ZC   = 2'd1;

    // Command queue between front and core
    localparam int QDEPTH = 2;
    localparam int QPW    = 1;
    localparam int QCW    = 2;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_ZC,
        OP_CMD
    } t_op;

    typedef struct packed {
        logic [1:0] channel;
        t_op        op;
        logic       in_range;
        logic       zc;
        logic       light;
        logic       sweep;
        logic       ld_level;
        logic       ld_target;
        logic [7:0] value;
        logic       ramp_req;
    } t_cmd;

    typedef struct packed {
        logic           valid;
        logic [QCW-1:0] cnt;
    } t_q_stat;

    typedef struct packed {
        logic       cycle_started;
        logic       gate_window;
        logic       step_pending;
        logic [7:0] phase_count;
        logic [7:0] div_count;
        logic [7:0] level;
        logic [7:0] target;
        logic       sweep_dir;
        logic       ramp_active;
        logic       gate;
    } t_chan;

endpackage

/* rtl/phase_cut_dimmer_with_ramp.sv */
// Trailing-edge phase dimmer for up to CHANNELS mains channels. Each input word
// addresses one channel and carries level/target loads, a ramp request and
// one event (timer tick, zero-cross edge, or commands only); it yields exactly
// one result word with that channel's gate, level, ramp and sweep status.
// One word is taken per clock cycle when the output is not stalled; a result
// passes first through the two-word command queue and then through the
// channel update that feeds the output register. The per-channel state is
// read, updated and written back in the cycle the word leaves the queue,
// so words for the same channel may follow each other without a gap.
// Configuration writes are taken every cycle (o_cfg_ready is always high).
module phase_cut_dimmer_with_ramp #(
    parameter int CHANNELS = 3
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_channel,
    input  logic [1:0] i_mode,
    input  logic       i_zero_cross_level,
    input  logic       i_light_on,
    input  logic       i_sweep_enable,
    input  logic       i_load_level,
    input  logic       i_load_target,
    input  logic [7:0] i_value,
    input  logic       i_ramp_request,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_out_channel,
    output logic       o_gate_on,
    output logic [7:0] o_level_now,
    output logic       o_ramp_busy,
    output logic       o_sweep_down,
    output logic       o_cycle_running
);
    import pcd_pkg::*;

    t_cmd    w_cmd;
    t_q_stat w_stat;
    logic    w_pop;

    assign o_cfg_ready = 1'b1;

    pcd_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_channel          (i_channel),
        .i_mode             (i_mode),
        .i_zero_cross_level (i_zero_cross_level),
        .i_light_on         (i_light_on),
        .i_sweep_enable     (i_sweep_enable),
        .i_load_level       (i_load_level),
        .i_load_target      (i_load_target),
        .i_value            (i_value),
        .i_ramp_request     (i_ramp_request),
        .o_cmd              (w_cmd),
        .i_cmd_pop          (w_pop),
        .o_stat             (w_stat)
    );

    pcd_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (w_cmd),
        .i_stat          (w_stat),
        .o_cmd_pop       (w_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_channel   (o_out_channel),
        .o_gate_on       (o_gate_on),
        .o_level_now     (o_level_now),
        .o_ramp_busy     (o_ramp_busy),
        .o_sweep_down    (o_sweep_down),
        .o_cycle_running (o_cycle_running)
    );

`ifndef SYNTHESIS
    // queue never overfills
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(w_stat.cnt) <= QDEPTH)
        else $error("command queue overfilled");

    // no bubble: a queued word moves on whenever the output register is free
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.valid && !o_valid) |-> w_pop)
        else $error("queued word not taken while output free");

    // a word for a channel that does not exist reports all-zero status
    a_bad_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (32'(o_out_channel) >= CHANNELS)) |->
        (!o_gate_on && (o_level_now == 8'd0) && !o_ramp_busy &&
         !o_sweep_down && !o_cycle_running))
        else $error("out-of-range channel result not cleared");
`endif

endmodule

/* rtl/pcd_front.sv */
module pcd_front #(
    parameter int CHANNELS = 3
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [1:0]      i_channel,
    input  logic [1:0]      i_mode,
    input  logic            i_zero_cross_level,
    input  logic            i_light_on,
    input  logic            i_sweep_enable,
    input  logic            i_load_level,
    input  logic            i_load_target,
    input  logic [7:0]      i_value,
    input  logic            i_ramp_request,
    output pcd_pkg::t_cmd   o_cmd,
    input  logic            i_cmd_pop,
    output pcd_pkg::t_q_stat o_stat
);
    import pcd_pkg::*;

    t_cmd           r_q [QDEPTH];
    logic [QPW-1:0] r_wr_ptr;
    logic [QPW-1:0] r_rd_ptr;
    logic [QCW-1:0] r_cnt;
    t_cmd           w_cmd;
    logic           w_push;

    // classify the incoming word
    always_comb begin
        w_cmd           = '0;
        w_cmd.channel   = i_channel;
        w_cmd.in_range  = (32'(i_channel) < CHANNELS);
        w_cmd.zc        = i_zero_cross_level;
        w_cmd.light     = i_light_on;
        w_cmd.sweep     = i_sweep_enable;
        w_cmd.ld_level  = i_load_level;
        w_cmd.ld_target = i_load_target;
        w_cmd.value     = i_value;
        w_cmd.ramp_req  = i_ramp_request;
        case (i_mode)
            MODE_TICK: w_cmd.op = OP_TICK;
            MODE_ZC:   w_cmd.op = OP_ZC;
            default:   w_cmd.op = OP_CMD;   // commands only, mode three too
        endcase
    end

    assign o_ready = (r_cnt != QCW'(QDEPTH));
    assign w_push  = i_valid && o_ready;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, i_cmd_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_cmd        = r_q[r_rd_ptr];
    assign o_stat.valid = (r_cnt != '0);
    assign o_stat.cnt   = r_cnt;

endmodule

/* rtl/pcd_core.sv */
module pcd_core #(
    parameter int CHANNELS = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [1:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data,
    input  pcd_pkg::t_cmd    i_cmd,
    input  pcd_pkg::t_q_stat i_stat,
    output logic             o_cmd_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_out_channel,
    output logic             o_gate_on,
    output logic [7:0]       o_level_now,
    output logic             o_ramp_busy,
    output logic             o_sweep_down,
    output logic             o_cycle_running
);
    import pcd_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // channel state after reset: idle, level and target at the reset level_max
    localparam t_chan CHAN_RST = '{
        cycle_started: 1'b0,
        gate_window:   1'b0,
        step_pending:  1'b0,
        phase_count:   8'd0,
        div_count:     8'd0,
        level:         RST_LEVEL_MAX,
        target:        RST_LEVEL_MAX,
        sweep_dir:     1'b0,
        ramp_active:   1'b0,
        gate:          1'b0
    };

    logic [7:0]    r_level_max;
    logic [7:0]    r_level_min;
    logic [7:0]    r_ramp_div;
    t_chan         r_chan [CHANNELS];
    logic          r_valid;
    logic [1:0]    r_out_channel;
    t_chan         r_out;

    logic [CW+1:0] w_ch_ext;
    logic [CW-1:0] w_idx;
    t_chan         w_cur;
    t_chan         n_chan;
    logic [8:0]    w_next_phase;
    logic [8:0]    w_phase_end;
    logic [8:0]    w_next_div;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_max <= RST_LEVEL_MAX;
            r_level_min <= RST_LEVEL_MIN;
            r_ramp_div  <= RST_RAMP_DIVIDER;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LEVEL_MAX:    r_level_max <= i_cfg_data;
                REG_LEVEL_MIN:    r_level_min <= i_cfg_data;
                REG_RAMP_DIVIDER: r_ramp_div  <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // take a word whenever the output register is free or drains this cycle
    assign o_cmd_pop = i_stat.valid && (!r_valid || i_ready);

    assign w_ch_ext = {{CW{1'b0}}, i_cmd.channel};
    assign w_idx    = w_ch_ext[CW-1:0];
    assign w_cur    = r_chan[w_idx];

    // per-word channel update: commands first, then the event
    always_comb begin
        n_chan       = w_cur;
        w_next_phase = '0;
        w_phase_end  = {1'b0, r_level_max} + 9'd1;
        w_next_div   = '0;

        if (i_cmd.ld_level)  n_chan.level       = i_cmd.value;
        if (i_cmd.ld_target) n_chan.target      = i_cmd.value;
        if (i_cmd.ramp_req)  n_chan.ramp_active = 1'b1;
        if (!i_cmd.light)    n_chan.gate        = 1'b0;

        case (i_cmd.op)
            OP_ZC: begin
                if (!n_chan.cycle_started && i_cmd.zc) begin
                    n_chan.cycle_started = 1'b1;
                    n_chan.gate_window   = 1'b1;
                    if (i_cmd.light) n_chan.gate = 1'b1;
                end
            end
            OP_TICK: begin
                // phase counter ends the half-cycle at level_max+1
                if (n_chan.cycle_started) begin
                    w_next_phase = {1'b0, n_chan.phase_count} + 9'd1;
                    if (w_next_phase >= w_phase_end) begin
                        n_chan.phase_count   = '0;
                        n_chan.cycle_started = 1'b0;
                    end else begin
                        n_chan.phase_count = w_next_phase[7:0];
                    end
                end
                if (n_chan.gate_window) begin
                    // trailing edge: gate off once the count reaches the level
                    if (n_chan.phase_count >= n_chan.level) begin
                        n_chan.gate_window  = 1'b0;
                        n_chan.step_pending = 1'b1;
                        if (i_cmd.light) n_chan.gate = 1'b0;
                    end
                end else if (n_chan.step_pending) begin
                    w_next_div          = {1'b0, n_chan.div_count} + 9'd1;
                    n_chan.step_pending = 1'b0;
                    if (w_next_div >= {1'b0, r_ramp_div}) begin
                        n_chan.div_count = '0;
                        if (i_cmd.sweep) begin
                            if (!n_chan.sweep_dir) begin
                                if (n_chan.level < r_level_max)
                                    n_chan.level = n_chan.level + 8'd1;
                                else
                                    n_chan.sweep_dir = 1'b1;
                            end else begin
                                if (n_chan.level > r_level_min)
                                    n_chan.level = n_chan.level - 8'd1;
                                else
                                    n_chan.sweep_dir = 1'b0;
                            end
                        end else if (n_chan.ramp_active) begin
                            if (n_chan.level < n_chan.target)
                                n_chan.level = n_chan.level + 8'd1;
                            else if (n_chan.level > n_chan.target)
                                n_chan.level = n_chan.level - 8'd1;
                            else
                                n_chan.ramp_active = 1'b0;
                        end
                    end else begin
                        n_chan.div_count = w_next_div[7:0];
                    end
                end
            end
            default: ;
        endcase
    end

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_chan[i] <= CHAN_RST;
            end
        end else if (o_cmd_pop && i_cmd.in_range) begin
            r_chan[w_idx] <= n_chan;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_cmd_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_out_channel <= i_cmd.channel;
            r_out         <= i_cmd.in_range ? n_chan : '0;
        end
    end

    assign o_valid         = r_valid;
    assign o_out_channel   = r_out_channel;
    assign o_gate_on       = r_out.gate;
    assign o_level_now     = r_out.level;
    assign o_ramp_busy     = r_out.ramp_active;
    assign o_sweep_down    = r_out.sweep_dir;
    assign o_cycle_running = r_out.cycle_started;

endmodule

/* bench/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pcd_pkg::*;

    localparam int NCH = 3;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_WORDS = 64;

    // Mode codes not named in the package
    localparam logic [1:0] MODE_CMD  = 2'd2;
    localparam logic [1:0] MODE_RSVD = 2'd3;
    // Register index with no register behind it
    localparam logic [1:0] REG_NONE  = 2'd3;

    typedef struct {
        logic [1:0] ch;
        logic [1:0] mode;
        logic       zc;
        logic       light;
        logic       sweep;
        logic       ld_level;
        logic       ld_target;
        logic [7:0] value;
        logic       ramp_req;
    } t_dim_word;

    typedef struct {
        logic [1:0] ch;
        logic       gate;
        logic [7:0] level;
        logic       busy;
        logic       down;
        logic       running;
    } t_dim_status;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [1:0] i_channel = '0;
    logic [1:0] i_mode = '0;
    logic       i_zero_cross_level = 1'b0;
    logic       i_light_on = 1'b0;
    logic       i_sweep_enable = 1'b0;
    logic       i_load_level = 1'b0;
    logic       i_load_target = 1'b0;
    logic [7:0] i_value = '0;
    logic       i_ramp_request = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [1:0] o_out_channel;
    logic       o_gate_on;
    logic [7:0] o_level_now;
    logic       o_ramp_busy;
    logic       o_sweep_down;
    logic       o_cycle_running;

    phase_cut_dimmer_with_ramp #(.CHANNELS(NCH)) dut (.*);

    // Predictor copy of registers and per-channel state
    logic [7:0]  lvl_max;
    logic [7:0]  lvl_min;
    logic [7:0]  step_div;
    t_chan       chan_st [NCH];

    t_dim_word   word_backlog[$];
    t_dim_status status_due[$];
    int          words_queued = 0;
    int          words_taken = 0;
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    logic        in_fire = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_dim_word make_word(logic [1:0] ch, logic [1:0] mode, logic zc,
                                            logic light, logic sweep, logic ld_level,
                                            logic ld_target, logic [7:0] value,
                                            logic ramp_req);
        t_dim_word w;
        w.ch = ch;
        w.mode = mode;
        w.zc = zc;
        w.light = light;
        w.sweep = sweep;
        w.ld_level = ld_level;
        w.ld_target = ld_target;
        w.value = value;
        w.ramp_req = ramp_req;
        return w;
    endfunction

    // Fully random word, any channel and mode
    function automatic t_dim_word noise_word();
        return make_word(2'($urandom), 2'($urandom), 1'($urandom), 1'($urandom),
                         1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom),
                         1'($urandom));
    endfunction

    // Apply one word to the channel state and return the status it reports
    function automatic t_dim_status dimmer_predict(t_dim_word w);
        t_dim_status r;
        t_chan       c;
        logic [8:0]  nxt;
        r = '{ch: w.ch, gate: 1'b0, level: 8'd0, busy: 1'b0, down: 1'b0, running: 1'b0};
        if (w.ch >= NCH)
            return r;
        c = chan_st[w.ch];

        // commands go first
        if (w.ld_level)  c.level = w.value;
        if (w.ld_target) c.target = w.value;
        if (w.ramp_req)  c.ramp_active = 1'b1;
        if (!w.light)    c.gate = 1'b0;

        if (w.mode == MODE_ZC) begin
            if (!c.cycle_started && w.zc) begin
                c.cycle_started = 1'b1;
                c.gate_window = 1'b1;
                if (w.light) c.gate = 1'b1;
            end
        end else if (w.mode == MODE_TICK) begin
            // phase counter ends at level_max + 1
            if (c.cycle_started) begin
                nxt = {1'b0, c.phase_count} + 9'd1;
                if (nxt >= {1'b0, lvl_max} + 9'd1) begin
                    c.phase_count = '0;
                    c.cycle_started = 1'b0;
                end else begin
                    c.phase_count = nxt[7:0];
                end
            end
            if (c.gate_window) begin
                if (c.phase_count >= c.level) begin
                    c.gate_window = 1'b0;
                    c.step_pending = 1'b1;
                    if (w.light) c.gate = 1'b0;
                end
            end else if (c.step_pending) begin
                nxt = {1'b0, c.div_count} + 9'd1;
                c.step_pending = 1'b0;
                if (nxt >= {1'b0, step_div}) begin
                    c.div_count = '0;
                    // sweep wins over the target ramp
                    if (w.sweep) begin
                        if (!c.sweep_dir) begin
                            if (c.level < lvl_max) c.level = c.level + 8'd1;
                            else c.sweep_dir = 1'b1;
                        end else begin
                            if (c.level > lvl_min) c.level = c.level - 8'd1;
                            else c.sweep_dir = 1'b0;
                        end
                    end else if (c.ramp_active) begin
                        if (c.level < c.target) c.level = c.level + 8'd1;
                        else if (c.level > c.target) c.level = c.level - 8'd1;
                        else c.ramp_active = 1'b0;
                    end
                end else begin
                    c.div_count = nxt[7:0];
                end
            end
        end

        chan_st[w.ch] = c;
        r.gate = c.gate;
        r.level = c.level;
        r.busy = c.ramp_active;
        r.down = c.sweep_dir;
        r.running = c.cycle_started;
        return r;
    endfunction

    task automatic note_mismatch(string what, int got, int want);
        $display("%0t ns: %s mismatch, got %0d want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Sender: bursts of words with random gaps between them
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge i_clk) begin : driver
        t_dim_word w;
        if (!i_valid || in_fire) begin
            if (gap_left != 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (word_backlog.size() != 0) begin
                w = word_backlog.pop_front();
                i_channel <= w.ch;
                i_mode <= w.mode;
                i_zero_cross_level <= w.zc;
                i_light_on <= w.light;
                i_sweep_enable <= w.sweep;
                i_load_level <= w.ld_level;
                i_load_target <= w.ld_target;
                i_value <= w.value;
                i_ramp_request <= w.ramp_req;
                i_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls follow a rotating 16-bit pattern, reloaded now and then
    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_age = 0;

    always @(negedge i_clk) begin : receiver
        if (pattern_age == 48) begin
            pattern_age = 0;
            case ($urandom_range(0, 3))
                0: ready_pattern = 16'hFFFF;
                1: ready_pattern = 16'($urandom);
                2: ready_pattern = 16'h0101;
                default: ready_pattern = 16'($urandom | $urandom);
            endcase
            if (ready_pattern == '0) ready_pattern = 16'hFFFF;
        end
        pattern_age++;
        ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
        i_ready <= ready_pattern[15];
    end

    // Monitor: check results, then record expectations for accepted words
    always @(posedge i_clk) begin : monitor
        t_dim_status want;
        t_dim_word   w;
        in_fire = i_rst_n && i_valid && o_ready;
        if (i_rst_n && o_valid && i_ready) begin
            if (status_due.size() == 0) begin
                note_mismatch("unexpected result, out_channel", o_out_channel, -1);
            end else begin
                want = status_due.pop_front();
                if (o_out_channel !== want.ch)
                    note_mismatch("out_channel", o_out_channel, want.ch);
                if (o_gate_on !== want.gate)
                    note_mismatch("gate_on", o_gate_on, want.gate);
                if (o_level_now !== want.level)
                    note_mismatch("level_now", o_level_now, want.level);
                if (o_ramp_busy !== want.busy)
                    note_mismatch("ramp_busy", o_ramp_busy, want.busy);
                if (o_sweep_down !== want.down)
                    note_mismatch("sweep_down", o_sweep_down, want.down);
                if (o_cycle_running !== want.running)
                    note_mismatch("cycle_running", o_cycle_running, want.running);
            end
        end
        if (in_fire) begin
            w = make_word(i_channel, i_mode, i_zero_cross_level, i_light_on, i_sweep_enable,
                          i_load_level, i_load_target, i_value, i_ramp_request);
            status_due.push_back(dimmer_predict(w));
            words_taken++;
        end
        // watchdog bookkeeping
        if (in_fire || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    initial begin : watchdog
        do @(posedge i_clk); while (idle_cycles < STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic push_word(t_dim_word w);
        word_backlog.push_back(w);
        words_queued++;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk); while (words_taken != words_queued || status_due.size() != 0);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [7:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_LEVEL_MAX:    lvl_max = data;
            REG_LEVEL_MIN:    lvl_min = data;
            REG_RAMP_DIVIDER: step_div = data;
            default: ;
        endcase
    endtask

    task automatic set_dimmer(logic [7:0] lmax, logic [7:0] lmin, logic [7:0] div);
        cfg_write(REG_LEVEL_MAX, lmax);
        cfg_write(REG_LEVEL_MIN, lmin);
        cfg_write(REG_RAMP_DIVIDER, div);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly whole half-cycles (zero-cross then ticks) on one channel,
    // with unrelated noise words mixed in
    task automatic queue_traffic(int count);
        int         made;
        int         nticks;
        int         top;
        logic [1:0] ch;
        logic       light;
        logic       sweep;
        logic [7:0] val;
        made = 0;
        top = int'(lvl_max) + 1;
        while (made < count) begin
            if ($urandom_range(0, 4) == 0) begin
                push_word(noise_word());
                made++;
            end else begin
                ch = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, NCH - 1));
                light = ($urandom_range(0, 7) != 0);
                sweep = 1'($urandom_range(0, 1));
                val = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, top));
                push_word(make_word(ch, MODE_ZC, 1'b1, light, sweep,
                                    $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0,
                                    val, $urandom_range(0, 3) == 0));
                made++;
                nticks = $urandom_range(1, (top > 20) ? 24 : top + 2);
                repeat (nticks) begin
                    if ($urandom_range(0, 4) == 0)
                        push_word(make_word(2'($urandom), 2'($urandom), 1'($urandom),
                                            1'($urandom), 1'($urandom),
                                            $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0,
                                            8'($urandom), $urandom_range(0, 5) == 0));
                    else
                        push_word(make_word(ch, MODE_TICK, 1'($urandom), light, sweep,
                                            1'b0, 1'b0, 8'($urandom), 1'b0));
                    made++;
                end
            end
        end
    endtask

    initial begin : stimulus
        logic [7:0] lmax;
        lvl_max = RST_LEVEL_MAX;
        lvl_min = RST_LEVEL_MIN;
        step_div = RST_RAMP_DIVIDER;
        for (int i = 0; i < NCH; i++) begin
            chan_st[i] = '0;
            chan_st[i].level = RST_LEVEL_MAX;
            chan_st[i].target = RST_LEVEL_MAX;
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset settings
        // channel out of range, every flag set
        push_word(make_word(2'd3, MODE_ZC, 1, 1, 1, 1, 1, 8'hFF, 1));
        // both loads in one word, then the reserved mode as commands only
        push_word(make_word(2'd0, MODE_CMD, 0, 1, 0, 1, 1, 8'h02, 0));
        push_word(make_word(2'd0, MODE_RSVD, 0, 1, 0, 0, 1, 8'h05, 1));
        // low reference ignored, then start, then zero-cross while running
        push_word(make_word(2'd0, MODE_ZC, 0, 1, 0, 0, 0, 8'h00, 0));
        push_word(make_word(2'd0, MODE_ZC, 1, 1, 0, 0, 0, 8'h00, 0));
        push_word(make_word(2'd0, MODE_ZC, 1, 1, 0, 0, 0, 8'h00, 0));
        // count reaches level, gate off, then the pending step
        push_word(make_word(2'd0, MODE_TICK, 0, 1, 0, 0, 0, 8'h00, 0));
        push_word(make_word(2'd0, MODE_TICK, 0, 1, 0, 0, 0, 8'h00, 0));
        push_word(make_word(2'd0, MODE_TICK, 0, 1, 0, 0, 0, 8'h00, 0));
        // light off: gate cleared and zero-cross leaves it off
        push_word(make_word(2'd1, MODE_CMD, 0, 0, 0, 1, 0, 8'hAA, 0));
        push_word(make_word(2'd1, MODE_ZC, 1, 0, 0, 0, 0, 8'h00, 0));
        push_word(make_word(2'd1, MODE_TICK, 1, 0, 1, 0, 0, 8'h55, 0));
        push_word(make_word(2'd1, MODE_TICK, 0, 1, 1, 0, 0, 8'h00, 0));
        // level above the end of the count
        push_word(make_word(2'd2, MODE_CMD, 0, 1, 0, 1, 1, 8'hFF, 0));
        push_word(make_word(2'd2, MODE_ZC, 1, 1, 0, 0, 0, 8'h00, 0));
        push_word(make_word(2'd2, MODE_TICK, 0, 1, 0, 0, 0, 8'h00, 0));
        push_word(make_word(2'd2, MODE_TICK, 0, 0, 0, 1, 0, 8'h00, 0));
        push_word(make_word(2'd2, MODE_TICK, 0, 1, 1, 0, 0, 8'h00, 0));
        push_word(make_word(2'd0, MODE_RSVD, 1, 1, 1, 0, 0, 8'h00, 1));
        push_word(make_word(2'd3, MODE_TICK, 0, 0, 0, 0, 0, 8'h00, 0));
        wait_idle();

        // Random phases, extremes first
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: begin
                    cfg_write(REG_NONE, 8'hA5);
                    set_dimmer(8'd0, 8'd0, 8'd1);
                end
                1: set_dimmer(8'd254, 8'd0, 8'd255);
                2: set_dimmer(8'd5, 8'd254, 8'd1);
                default: begin
                    lmax = 8'($urandom_range(2, 12));
                    set_dimmer(lmax, 8'($urandom_range(0, lmax)), 8'($urandom_range(1, 3)));
                end
            endcase
            queue_traffic(PHASE_WORDS);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && status_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
